FILE: rtl/ttps_pkg.sv
// shared types, constants and helpers for the transposition table probe/store unit
// no dependencies; used by ttps_eval and the top level
package ttps_pkg;

    localparam int INDEX_BITS    = 16;
    localparam int TABLE_ENTRIES = 1 << INDEX_BITS;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 8;
    localparam int MOVE_W  = 16;
    localparam int SCORE_W = 21;
    localparam int PLY_W   = 8;
    localparam int MATE_W  = 19;
    localparam int THR_W   = 22;
    localparam int WIDE_W  = 23;

    localparam int MATE_WINDOW = 1000;
    localparam int MATE_RESET  = 100000;

    localparam logic signed [WIDE_W-1:0] SCORE_MAX = 23'sd1048575;
    localparam logic signed [WIDE_W-1:0] SCORE_MIN = -23'sd1048576;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        BOUND_EMPTY = 2'd0,
        BOUND_EXACT = 2'd1,
        BOUND_LOWER = 2'd2,
        BOUND_UPPER = 2'd3
    } bound_t;

    typedef struct packed {
        op_t                        op;
        logic [KEY_W-1:0]           hash_key;
        logic [DEPTH_W-1:0]         search_depth;
        logic signed [SCORE_W-1:0]  window_low;
        logic signed [SCORE_W-1:0]  window_high;
        logic [PLY_W-1:0]           ply_distance;
        logic [MOVE_W-1:0]          best_move;
        logic signed [SCORE_W-1:0]  score;
    } item_t;

    typedef struct packed {
        bound_t                     bound;
        logic signed [SCORE_W-1:0]  score;
        logic [MOVE_W-1:0]          move;
        logic [DEPTH_W-1:0]         depth;
        logic [KEY_W-1:0]           key;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic                       move_found;
        logic [MOVE_W-1:0]          hash_move;
        logic                       score_valid;
        logic signed [SCORE_W-1:0]  table_score;
    } result_t;

    typedef struct packed {
        logic    wr_en;
        entry_t  wr_entry;
        result_t res;
    } eval_t;

    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] c;
        begin
            if (v > SCORE_MAX)
            begin
                c = SCORE_MAX;
            end
            else if (v < SCORE_MIN)
            begin
                c = SCORE_MIN;
            end
            else
            begin
                c = v;
            end
            sat_score = c[SCORE_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/ttps_ram.sv
// generic simple dual-port ram with registered read data
// depends on nothing
module ttps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/ttps_eval.sv
// probe/store decision for one item against the entry read from the table
// depends on ttps_pkg
module ttps_eval
    import ttps_pkg::*;
(
    input  item_t                   item,
    input  entry_t                  entry,
    input  logic signed [THR_W-1:0] hi_thr,
    output eval_t                   ev
);

    logic signed [WIDE_W-1:0]  hi_w;
    logic signed [WIDE_W-1:0]  lo_w;
    logic signed [WIDE_W-1:0]  ply_w;
    logic signed [WIDE_W-1:0]  stored_w;
    logic signed [WIDE_W-1:0]  val_w;
    logic signed [WIDE_W-1:0]  probe_adj;
    logic signed [WIDE_W-1:0]  store_adj;
    logic signed [SCORE_W-1:0] probe_s;
    logic                      key_eq;
    logic                      found;
    logic                      depth_ok;
    logic                      bound_ok;

    always_comb
    begin
        hi_w     = WIDE_W'(hi_thr);
        lo_w     = -hi_w;
        ply_w    = $signed({{(WIDE_W-PLY_W){1'b0}}, item.ply_distance});
        stored_w = WIDE_W'(entry.score);
        val_w    = WIDE_W'(item.score);
        key_eq   = (entry.key == item.hash_key);

        // probe: stored mate scores back to root-relative
        if (stored_w > hi_w)
        begin
            probe_adj = stored_w - ply_w;
        end
        else if (stored_w < lo_w)
        begin
            probe_adj = stored_w + ply_w;
        end
        else
        begin
            probe_adj = stored_w;
        end
        probe_s = sat_score(probe_adj);

        found    = (entry.bound != BOUND_EMPTY) && key_eq;
        depth_ok = (entry.depth >= item.search_depth);
        bound_ok = (entry.bound == BOUND_EXACT)
                || (entry.bound == BOUND_LOWER && probe_s >= item.window_high)
                || (entry.bound == BOUND_UPPER && probe_s <= item.window_low);

        // store: mate scores made ply-relative
        if (val_w > hi_w)
        begin
            store_adj = val_w + ply_w;
        end
        else if (val_w < lo_w)
        begin
            store_adj = val_w - ply_w;
        end
        else
        begin
            store_adj = val_w;
        end

        ev.wr_entry.key   = item.hash_key;
        ev.wr_entry.depth = item.search_depth;
        ev.wr_entry.move  = item.best_move;
        ev.wr_entry.score = sat_score(store_adj);
        if (item.score <= item.window_low)
        begin
            ev.wr_entry.bound = BOUND_UPPER;
        end
        else if (item.score >= item.window_high)
        begin
            ev.wr_entry.bound = BOUND_LOWER;
        end
        else
        begin
            ev.wr_entry.bound = BOUND_EXACT;
        end

        ev.wr_en = (item.op == OP_STORE) && (key_eq || entry.depth <= item.search_depth);

        ev.res = '0;
        if (item.op == OP_PROBE && found)
        begin
            ev.res.move_found = 1'b1;
            ev.res.hash_move  = entry.move;
            if (depth_ok && bound_ok)
            begin
                ev.res.score_valid = 1'b1;
                ev.res.table_score = probe_s;
            end
        end
    end

endmodule

FILE: rtl/transposition_table_probe_store_unit.sv
// top level of the transposition table probe/store unit
// depends on ttps_pkg, ttps_ram and ttps_eval

// Direct-mapped transposition table of 65536 entries indexed by hash_key[15:0],
// held in one ram with registered read data. Each probe, store or no-op item
// has its entry read on acceptance, then in the look state is evaluated,
// written back and loaded into the result register; a waiting result does not
// hold up the next item unless a second result is ready before the first is
// taken. A clear item returns its all-zero result at once and then walks the
// table writing one entry per cycle with no item accepted; the same pass runs
// after reset. mate_level is written over the cfg channel, which never stalls;
// the user must write it only with no item in flight; the block does not check.
module transposition_table_probe_store_unit
    import ttps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [MATE_W-1:0]  cfg_data,       // mate_level
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // hash_key, search_depth, window_low, window_high, ply_distance, best_move,
    // score, one zero pad bit
    input  logic [159:0]       s_axis_tdata,
    input  logic [1:0]         s_axis_tuser,   // op
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // move_found, hash_move, score_valid, table_score, one zero pad bit
    output logic [39:0]        m_axis_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [INDEX_BITS-1:0]   clr_reg, clr_next;
    logic signed [THR_W-1:0] hi_thr_reg;
    item_t                   item_reg;
    logic                    out_valid_reg, out_valid_next;
    result_t                 out_reg;

    item_t                   in_item;
    entry_t                  rd_entry;
    logic [ENTRY_W-1:0]      rd_data;
    eval_t                   ev;
    logic                    accept;
    logic                    finish;
    logic                    ram_we;
    logic [INDEX_BITS-1:0]   ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_item.op           = op_t'(s_axis_tuser);
        in_item.hash_key     = s_axis_tdata[63:0];
        in_item.search_depth = s_axis_tdata[71:64];
        in_item.window_low   = s_axis_tdata[92:72];
        in_item.window_high  = s_axis_tdata[113:93];
        in_item.ply_distance = s_axis_tdata[121:114];
        in_item.best_move    = s_axis_tdata[137:122];
        in_item.score        = s_axis_tdata[158:138];
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign finish        = (state_reg == S_LOOK) && (!out_valid_reg || m_axis_tready);

    assign rd_entry = entry_t'(rd_data);

    ttps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_item.hash_key[INDEX_BITS-1:0]),
        .rdata (rd_data)
    );

    ttps_eval u_eval (
        .item   (item_reg),
        .entry  (rd_entry),
        .hi_thr (hi_thr_reg),
        .ev     (ev)
    );

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = finish && ev.wr_en;
            ram_waddr = item_reg.hash_key[INDEX_BITS-1:0];
            ram_wdata = ENTRY_W'(ev.wr_entry);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    if (item_reg.op == OP_CLEAR)
                    begin
                        state_next = S_CLEAR;
                        clr_next   = '0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            hi_thr_reg    <= THR_W'(MATE_RESET - MATE_WINDOW);
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                hi_thr_reg <= $signed({{(THR_W-MATE_W){1'b0}}, cfg_data})
                            - THR_W'(MATE_WINDOW);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (finish)
        begin
            out_reg <= ev.res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.table_score, out_reg.score_valid,
                            out_reg.hash_move, out_reg.move_found};

endmodule
